>>> rtl/core/sacl_pkg.sv
// Package: cache geometry, address split helpers and the controller command type.
`default_nettype none
package sacl_pkg;
  localparam int unsigned Sets       = 16;
  localparam int unsigned Ways       = 4;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned OffW  = (BlockWords > 1) ? $clog2(BlockWords) : 1;
  localparam int unsigned SetW  = (Sets > 1) ? $clog2(Sets) : 1;
  localparam int unsigned WayW  = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned OffBits = $clog2(BlockWords);
  localparam int unsigned SetBits = $clog2(Sets);
  localparam int unsigned TagW  = 32 - OffBits - SetBits;
  localparam int unsigned DataDepth = Sets * Ways * BlockWords;
  localparam int unsigned DataAw = $clog2(DataDepth) > 0 ? $clog2(DataDepth) : 1;

  localparam logic CmdRead  = 1'b0;
  localparam logic CmdWrite = 1'b1;

  typedef logic [WayW-1:0] way_t;

  // Controller to datapath commands
  typedef struct packed {
    logic lookup;   // capture request and read the tag store
    logic update;   // write back tag, lru and data, load result register
  } dp_cmd_t;
endpackage
`default_nettype wire

>>> rtl/core/sacl_if.sv
// Interfaces: request and result channels.
`default_nettype none
interface sacl_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] addr;
  logic [31:0] write_data;
  modport source (output valid, cmd, addr, write_data, input ready);
  modport sink   (input valid, cmd, addr, write_data, output ready);
endinterface

interface sacl_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [31:0] read_data;
  logic        data_valid;
  modport source (output valid, hit, read_data, data_valid, input ready);
  modport sink   (input valid, hit, read_data, data_valid, output ready);
endinterface
`default_nettype wire

>>> rtl/core/sacl_datapath.sv
// Datapath: tag, valid, LRU and data stores with hit detection.
`default_nettype none
module sacl_datapath (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire sacl_pkg::dp_cmd_t cmd_i,
  input  wire                 req_cmd_i,
  input  wire [31:0]          req_addr_i,
  input  wire [31:0]          req_wdata_i,
  output logic                res_hit_o,
  output logic [31:0]         res_rdata_o,
  output logic                res_dvalid_o
);
  import sacl_pkg::*;

  logic [Ways-1:0][TagW-1:0] tag_mem [Sets];
  logic [31:0]      data_mem [DataDepth];
  logic [Ways-1:0]  valid_q [Sets];
  way_t             lru_q [Sets][Ways];

  logic             cmd_q;
  logic [OffW-1:0]  off_q;
  logic [SetW-1:0]  set_q;
  logic [TagW-1:0]  tag_q;
  logic [31:0]      wdata_q;
  logic [Ways-1:0][TagW-1:0] tags_q;
  logic [31:0]      rd_q;

  logic [OffW-1:0]  off_c;
  logic [SetW-1:0]  set_c;
  logic [TagW-1:0]  tag_c;
  logic             hit_c;
  way_t             hit_way_c;
  way_t             way_c;
  logic [WayW:0]    pos_c;
  way_t             new_lru_c [Ways];
  logic [Ways-1:0][TagW-1:0] tag_wr_c;

  // Split the address into fields
  always_comb begin
    off_c = '0;
    set_c = '0;
    if (OffBits > 0) off_c = OffW'(req_addr_i);
    if (SetBits > 0) set_c = SetW'(req_addr_i >> OffBits);
    tag_c = TagW'(req_addr_i >> (OffBits + SetBits));
  end

  // Read the set's tags during lookup
  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      cmd_q   <= req_cmd_i;
      off_q   <= off_c;
      set_q   <= set_c;
      tag_q   <= tag_c;
      wdata_q <= req_wdata_i;
      tags_q  <= tag_mem[set_c];
    end
  end

  // Compare tags and pick way
  always_comb begin
    hit_c = 1'b0;
    hit_way_c = '0;
    for (int w = Ways - 1; w >= 0; w--) begin
      if (valid_q[set_q][w] && tags_q[w] == tag_q) begin
        hit_c = 1'b1;
        hit_way_c = WayW'(w);
      end
    end
    pos_c = '0;
    for (int k = 0; k < Ways; k++) begin
      if (lru_q[set_q][k] == hit_way_c) pos_c = (WayW+1)'(k);
    end
    if (!hit_c) pos_c = '0;
    way_c = hit_c ? hit_way_c : lru_q[set_q][0];
    for (int k = 0; k < Ways; k++) begin
      if ((WayW+1)'(k) < pos_c || k == Ways - 1) begin
        new_lru_c[k] = (k == Ways - 1) ? way_c : lru_q[set_q][k];
      end else begin
        new_lru_c[k] = lru_q[set_q][(k + 1) % Ways];
      end
    end
  end

  // Replace the victim's tag in the set word
  always_comb begin
    tag_wr_c = tags_q;
    tag_wr_c[way_c] = tag_q;
  end

  // Write back tag and data stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      if (!hit_c) tag_mem[set_q] <= tag_wr_c;
      if (cmd_q == CmdWrite) begin
        data_mem[DataAw'((((32'(set_q) * Ways) + 32'(way_c)) * BlockWords) + 32'(off_q))]
          <= wdata_q;
      end
    end
  end

  // Read the data store during update
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      rd_q <= data_mem[DataAw'((((32'(set_q) * Ways) + 32'(hit_way_c)) * BlockWords)
                      + 32'(off_q))];
    end
  end

  // Valid bits and LRU order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < Sets; s++) begin
        valid_q[s] <= '0;
        for (int k = 0; k < Ways; k++) lru_q[s][k] <= WayW'(k);
      end
    end else if (cmd_i.update) begin
      valid_q[set_q][way_c] <= 1'b1;
      for (int k = 0; k < Ways; k++) lru_q[set_q][k] <= new_lru_c[k];
    end
  end

  // Result register
  logic res_hit_q, res_rd_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_hit_q <= 1'b0;
      res_rd_q  <= 1'b0;
    end else if (cmd_i.update) begin
      res_hit_q <= hit_c;
      res_rd_q  <= hit_c && (cmd_q == CmdRead);
    end
  end

  assign res_hit_o    = res_hit_q;
  assign res_dvalid_o = res_rd_q;
  assign res_rdata_o  = res_rd_q ? rd_q : 32'd0;
endmodule
`default_nettype wire

>>> rtl/core/sacl_ctrl.sv
// Controller: sequences lookup, update and result handoff.
`default_nettype none
module sacl_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                req_valid_i,
  output logic               req_ready_o,
  output logic               rsp_valid_o,
  input  wire                rsp_ready_i,
  output sacl_pkg::dp_cmd_t  cmd_o
);
  import sacl_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StUpd  = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    req_ready_o = 1'b0;
    rsp_valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.lookup = 1'b1;
          state_d = StUpd;
        end
      end
      StUpd: begin
        cmd_o.update = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

  // One request in flight at a time
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !req_ready_o) else $error("request taken while result pending");
  a_accept_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> cmd_o.update) else $error("no update after accept");
  a_update_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.update |=> rsp_valid_o) else $error("no result after update");
endmodule
`default_nettype wire

>>> rtl/core/set_assoc_cache_lru_unit.sv
// Top level: set-associative cache with true LRU and write allocate.
//  channel | dir | fields
//  req     | in  | cmd, addr, write_data
//  rsp     | out | hit, read_data, data_valid
// After a request is accepted the controller runs lookup, then update, then
// presents the result: lookup reads the tag store, update writes tag, LRU and
// data back to the same set. The next request is taken once the result is
// accepted, so only one request is in flight at a time; ready low stalls it.
// Reset clears valid bits and restores LRU order at once; no clearing pass.
`default_nettype none
module set_assoc_cache_lru_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  sacl_req_if.sink    req,
  sacl_rsp_if.source  rsp
);
  import sacl_pkg::*;

  dp_cmd_t cmd;

  sacl_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .req_valid_i (req.valid), .req_ready_o (req.ready),
    .rsp_valid_o (rsp.valid), .rsp_ready_i (rsp.ready),
    .cmd_o (cmd)
  );

  sacl_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i (cmd),
    .req_cmd_i (req.cmd), .req_addr_i (req.addr), .req_wdata_i (req.write_data),
    .res_hit_o (rsp.hit), .res_rdata_o (rsp.read_data), .res_dvalid_o (rsp.data_valid)
  );
endmodule
`default_nettype wire

>>> sim/set_assoc_cache_lru_unit_tb.sv
// Testbench for the LRU cache unit: random and directed requests checked against a predictor.
module set_assoc_cache_lru_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sacl_pkg::*;

  typedef struct packed {
    logic        cmd;
    logic [31:0] addr;
    logic [31:0] wdata;
  } access_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] rdata;
    logic        dvalid;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sacl_req_if req ();
  sacl_rsp_if rsp ();

  set_assoc_cache_lru_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req.sink),
    .rsp    (rsp.source)
  );

  // Shadow cache state
  logic [TagW-1:0] shadow_tag   [Sets][Ways];
  logic            shadow_valid [Sets][Ways];
  logic [31:0]     shadow_data  [Sets][Ways][BlockWords];
  way_t            shadow_order [Sets][Ways];
  // Words written since reset, so reads only target defined data
  bit              word_known   [Sets][Ways][BlockWords];

  access_t  pending_q[$];
  outcome_t awaited_q[$];
  int       errors = 0;
  int       send_idle_pct = 38;
  int       recv_idle_pct = 84;
  bit       stimulus_done = 1'b0;
  longint   cycle_cnt = 0;
  bit       req_taken = 1'b0;

  // Clock
  always #5 clk_i = ~clk_i;

  // Move a way to the most recently used end of its set's order
  function automatic void promote(int s, way_t w);
    int p;
    p = 0;
    for (int k = 0; k < Ways; k++) if (shadow_order[s][k] == w) p = k;
    for (int k = p; k < Ways - 1; k++) shadow_order[s][k] = shadow_order[s][k + 1];
    shadow_order[s][Ways - 1] = w;
  endfunction

  // Work out the result of one access and update the shadow state
  function automatic outcome_t cache_access(access_t a);
    outcome_t o;
    int off, s, hw;
    logic [TagW-1:0] t;
    off = a.addr % BlockWords;
    s   = (a.addr / BlockWords) % Sets;
    t   = TagW'(a.addr / (BlockWords * Sets));
    hw  = -1;
    for (int w = Ways - 1; w >= 0; w--)
      if (shadow_valid[s][w] && shadow_tag[s][w] == t) hw = w;
    o = '0;
    if (hw >= 0) begin
      promote(s, way_t'(hw));
      o.hit = 1'b1;
      if (a.cmd == CmdWrite) begin
        shadow_data[s][hw][off] = a.wdata;
        word_known[s][hw][off] = 1'b1;
      end else begin
        o.rdata  = shadow_data[s][hw][off];
        o.dvalid = 1'b1;
      end
    end else begin
      hw = shadow_order[s][0];
      promote(s, way_t'(hw));
      shadow_tag[s][hw] = t;
      shadow_valid[s][hw] = 1'b1;
      if (a.cmd == CmdWrite) begin
        for (int k = 0; k < BlockWords; k++) word_known[s][hw][k] = 1'b0;
        shadow_data[s][hw][off] = a.wdata;
        word_known[s][hw][off] = 1'b1;
      end else begin
        // read miss keeps old data; only words written earlier stay defined
        for (int k = 0; k < BlockWords; k++) word_known[s][hw][k] = word_known[s][hw][k];
      end
    end
    return o;
  endfunction

  // Would this read hit a word never written? Those must not be issued.
  function automatic bit reads_undefined(access_t a);
    int off, s;
    logic [TagW-1:0] t;
    off = a.addr % BlockWords;
    s   = (a.addr / BlockWords) % Sets;
    t   = TagW'(a.addr / (BlockWords * Sets));
    if (a.cmd == CmdWrite) return 1'b0;
    for (int w = 0; w < Ways; w++)
      if (shadow_valid[s][w] && shadow_tag[s][w] == t) return !word_known[s][w][off];
    return 1'b0;
  endfunction

  // Shadow used only at generation time to screen reads of undefined words
  logic [TagW-1:0] gen_tag   [Sets][Ways];
  logic            gen_valid [Sets][Ways];
  way_t            gen_order [Sets][Ways];
  bit              gen_known [Sets][Ways][BlockWords];

  function automatic void gen_promote(int s, way_t w);
    int p;
    p = 0;
    for (int k = 0; k < Ways; k++) if (gen_order[s][k] == w) p = k;
    for (int k = p; k < Ways - 1; k++) gen_order[s][k] = gen_order[s][k + 1];
    gen_order[s][Ways - 1] = w;
  endfunction

  // Queue a request; a read of an undefined word is swapped to a write
  function automatic void push_access(logic cmd, logic [31:0] addr, logic [31:0] wdata);
    int off, s, hw;
    logic [TagW-1:0] t;
    access_t a;
    off = addr % BlockWords;
    s   = (addr / BlockWords) % Sets;
    t   = TagW'(addr / (BlockWords * Sets));
    hw  = -1;
    for (int w = Ways - 1; w >= 0; w--)
      if (gen_valid[s][w] && gen_tag[s][w] == t) hw = w;
    if (hw >= 0 && cmd == CmdRead && !gen_known[s][hw][off]) cmd = CmdWrite;
    if (hw >= 0) begin
      gen_promote(s, way_t'(hw));
      if (cmd == CmdWrite) gen_known[s][hw][off] = 1'b1;
    end else begin
      hw = gen_order[s][0];
      gen_promote(s, way_t'(hw));
      gen_tag[s][hw] = t;
      gen_valid[s][hw] = 1'b1;
      if (cmd == CmdWrite) begin
        for (int k = 0; k < BlockWords; k++) gen_known[s][hw][k] = 1'b0;
        gen_known[s][hw][off] = 1'b1;
      end
    end
    a.cmd = cmd;
    a.addr = addr;
    a.wdata = wdata;
    pending_q = {pending_q, a};
  endfunction

  function automatic logic [31:0] make_addr(int s, int t, int off);
    return (32'(t) << (OffBits + SetBits)) | (32'(s) << OffBits) | 32'(off);
  endfunction

  // Driver: present requests from the pending queue
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req.valid <= 1'b0;
      req.cmd <= CmdRead;
      req.addr <= '0;
      req.write_data <= '0;
    end else if (!(req.valid && !req_taken)) begin
      if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        req.valid <= 1'b1;
        req.cmd <= pending_q[0].cmd;
        req.addr <= pending_q[0].addr;
        req.write_data <= pending_q[0].wdata;
        void'(pending_q.pop_front());
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // Receiver stalls
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rsp.ready <= 1'b0;
    else rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: predict on accepted requests, check accepted results
  always @(posedge clk_i) begin
    outcome_t exp_o;
    access_t  acc;
    cycle_cnt <= cycle_cnt + 1;
    req_taken = 1'b0;
    if (rst_ni && req.valid && req.ready) begin
      acc = '{req.cmd, req.addr, req.write_data};
      if (reads_undefined(acc)) begin
        $error("addr: read of unwritten word at %h", acc.addr);
        errors++;
      end
      awaited_q = {awaited_q, cache_access(acc)};
      req_taken = 1'b1;
    end
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (awaited_q.size() == 0) begin
        $error("unexpected result: hit %0b read_data %h", rsp.hit, rsp.read_data);
        errors++;
      end else begin
        exp_o = awaited_q.pop_front();
        if (rsp.hit !== exp_o.hit) begin
          $error("hit: expected %0b actual %0b", exp_o.hit, rsp.hit);
          errors++;
        end
        if (rsp.read_data !== exp_o.rdata) begin
          $error("read_data: expected %h actual %h", exp_o.rdata, rsp.read_data);
          errors++;
        end
        if (rsp.data_valid !== exp_o.dvalid) begin
          $error("data_valid: expected %0b actual %0b", exp_o.dvalid, rsp.data_valid);
          errors++;
        end
      end
    end
  end

  // Timeout
  always @(posedge clk_i) begin
    if (cycle_cnt > 400000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int s, off, r;
    for (int i = 0; i < Sets; i++)
      for (int w = 0; w < Ways; w++) begin
        shadow_valid[i][w] = 1'b0;
        shadow_tag[i][w] = '0;
        shadow_order[i][w] = way_t'(w);
        gen_valid[i][w] = 1'b0;
        gen_tag[i][w] = '0;
        gen_order[i][w] = way_t'(w);
        for (int k = 0; k < BlockWords; k++) begin
          shadow_data[i][w][k] = '0;
          word_known[i][w][k] = 1'b0;
          gen_known[i][w][k] = 1'b0;
        end
      end
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: read miss, write allocate, read hit, extremes, LRU eviction
    push_access(CmdRead, 32'h0000_0000, 32'h0);
    push_access(CmdWrite, 32'h0000_0000, 32'hFFFF_FFFF);
    push_access(CmdRead, 32'h0000_0000, 32'h0);
    push_access(CmdWrite, 32'hFFFF_FFFF, 32'h0000_0000);
    push_access(CmdRead, 32'hFFFF_FFFF, 32'h0);
    push_access(CmdRead, 32'hFFFF_FFF0, 32'h0);
    push_access(CmdWrite, 32'hAAAA_AAAA, 32'h5555_5555);
    push_access(CmdRead, 32'hAAAA_AAAA, 32'h0);
    for (int t = 1; t <= 5; t++) push_access(CmdWrite, make_addr(3, t, t), 32'(t * 7));
    push_access(CmdRead, make_addr(3, 1, 1), 32'h0);
    push_access(CmdRead, make_addr(3, 2, 2), 32'h0);
    push_access(CmdRead, make_addr(3, 6, 0), 32'h0);
    push_access(CmdRead, make_addr(3, 3, 3), 32'h0);
    push_access(CmdWrite, make_addr(3, 3, 9), 32'h1234_5678);
    push_access(CmdRead, make_addr(3, 3, 9), 32'h0);

    // Random phases: small tag pool per set so hits and evictions are frequent
    for (int ph = 0; ph < 3; ph++) begin
      for (int n = 0; n < 630; n++) begin
        r = $urandom_range(99);
        if (r < 10)
          push_access(1'($urandom), $urandom, $urandom);
        else
          push_access(1'($urandom), make_addr($urandom_range(Sets - 1),
                      $urandom_range(6) * 32'h0001_1111 ^ (r < 15 ? 32'hFF_FFFF : 0)
                      & 32'hFF_FFFF, $urandom_range(BlockWords - 1)), $urandom);
      end
      // Drain: sender holds off until all results have come
      do @(posedge clk_i);
      while (!(pending_q.size() == 0 && awaited_q.size() == 0 && !req.valid));
      if (ph == 0) begin
        send_idle_pct = 84;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    end
    repeat (10) @(posedge clk_i);
    if (errors == 0 && awaited_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

>>> set_assoc_cache_lru_unit.f
rtl/core/sacl_pkg.sv
rtl/core/sacl_if.sv
rtl/core/sacl_datapath.sv
rtl/core/sacl_ctrl.sv
rtl/core/set_assoc_cache_lru_unit.sv
sim/set_assoc_cache_lru_unit_tb.sv
